// ----- rtl/pvm_pkg.sv -----
// Shared types, codes and reciprocal constants of the pixel visual metric block.
package pvm_pkg;

  // Metric selection codes held in the data_mode register.
  typedef enum logic [2:0] {
    MODE_AVG_RGB    = 3'd0,
    MODE_AVG_RGBA   = 3'd1,
    MODE_ALPHA      = 3'd2,
    MODE_BLUE       = 3'd3,
    MODE_GREEN      = 3'd4,
    MODE_RED        = 3'd5,
    MODE_LIGHTNESS  = 3'd6,
    MODE_SATURATION = 3'd7
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DATA_MODE        = 3'd0,
    REG_RED_DROP_BITS    = 3'd1,
    REG_GREEN_DROP_BITS  = 3'd2,
    REG_BLUE_DROP_BITS   = 3'd3,
    REG_ALPHA_DROP_BITS  = 3'd4,
    REG_THRESHOLD_ENABLE = 3'd5,
    REG_THRESHOLD_LEVEL  = 3'd6
  } reg_idx_e;

  localparam int unsigned CfgWidth    = 17;
  localparam int unsigned FracWidth   = 17;
  localparam int unsigned RecipShift  = 26;
  localparam int unsigned RecipWidth  = 27;
  localparam int unsigned RecipOne    = 1 << RecipShift;
  localparam logic [16:0] ThresholdReset = 17'd32768;

  // Truncated reciprocals floor(2^26 / d) of the fixed denominators.
  localparam logic [26:0] RECIP_255  = 27'(RecipOne / 255);
  localparam logic [26:0] RECIP_510  = 27'(RecipOne / 510);
  localparam logic [26:0] RECIP_765  = 27'(RecipOne / 765);
  localparam logic [26:0] RECIP_1020 = 27'(RecipOne / 1020);

  typedef logic [RecipWidth-1:0] recip_tbl_t [256];

  // Entry zero holds the reciprocal of one; it serves the black pixel in
  // saturation mode, where the denominator is forced to one. The other
  // entries come from a restoring long division of 2^26 by the index.
  function automatic recip_tbl_t build_recip_tbl();
    recip_tbl_t  tbl;
    logic [27:0] rem;
    logic [26:0] quo;
    tbl[0] = 27'(RecipOne);
    for (int i = 1; i < 256; i++) begin
      rem = '0;
      quo = '0;
      for (int k = RecipShift; k >= 0; k--) begin
        rem = {rem[26:0], (k == RecipShift)};
        if (rem >= 28'(i)) begin
          rem    = rem - 28'(i);
          quo[k] = 1'b1;
        end
      end
      tbl[i] = quo;
    end
    return tbl;
  endfunction

  localparam recip_tbl_t RECIP_TBL = build_recip_tbl();

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [2:0] red;
    logic [2:0] green;
    logic [2:0] blue;
    logic [2:0] alpha;
  } drop_t;

  // Metric as an exact ratio num / den plus the reciprocal of den.
  typedef struct packed {
    logic [9:0]  num;
    logic [9:0]  den;
    logic [26:0] recip;
  } ratio_t;

  // Quotient estimates and their remainders, each estimate at most one low.
  typedef struct packed {
    logic [16:0] frac_est;
    logic [10:0] frac_rem;
    logic [7:0]  gray_est;
    logic [10:0] gray_rem;
    logic [9:0]  den;
  } est_t;

endpackage

// ----- rtl/pixel_visual_metric.sv -----
// Top level of the pixel visual metric block: configuration registers and pipeline.
//
//   channel   ports                                         direction  handshake
//   request   start_i, busy_o, red_i/green_i/blue_i/alpha_i  in         start_i && !busy_o
//   result    valid_o, level_fraction_o, gray_level_o      out        one-cycle strobe
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i              in         write on cfg_we_i
//
// One request is taken every cycle; busy_o is always low, since the five
// register stages move forward on every clock and nothing downstream can
// hold them. Each request passes through the mask, ratio, multiply,
// back-multiply and correction registers in that order. Reset clears the
// valid bits of all stages and loads the registers with their reset values.
// The receiver cannot stall, so no result is ever held or repeated.
module pixel_visual_metric
  import pvm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic [7:0]          alpha_i,
  output logic                valid_o,
  output logic [16:0]         level_fraction_o,
  output logic [7:0]          gray_level_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i
);

  // Configuration registers. The user must change them only while no request is in
  // flight; the block itself does not enforce this. Each stage reads them directly.
  mode_e       mode_q;
  drop_t       drop_q;
  logic        thr_en_q;
  logic [16:0] thr_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_AVG_RGB;
      drop_q      <= '0;
      thr_en_q    <= 1'b0;
      thr_level_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DATA_MODE:        mode_q       <= mode_e'(cfg_wdata_i[2:0]);
        REG_RED_DROP_BITS:    drop_q.red   <= cfg_wdata_i[2:0];
        REG_GREEN_DROP_BITS:  drop_q.green <= cfg_wdata_i[2:0];
        REG_BLUE_DROP_BITS:   drop_q.blue  <= cfg_wdata_i[2:0];
        REG_ALPHA_DROP_BITS:  drop_q.alpha <= cfg_wdata_i[2:0];
        REG_THRESHOLD_ENABLE: thr_en_q     <= cfg_wdata_i[0];
        REG_THRESHOLD_LEVEL:  thr_level_q  <= cfg_wdata_i[16:0];
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  // The pipeline never refuses a request.
  assign busy_o = 1'b0;

  pix_t   pix;
  logic   prep_valid, div_valid;
  ratio_t ratio;
  est_t   est;

  assign pix.red   = red_i;
  assign pix.green = green_i;
  assign pix.blue  = blue_i;
  assign pix.alpha = alpha_i;

  // Stages one and two: clear the low bits, then form the metric as num/den.
  pvm_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .pix_i   (pix),
    .drop_i  (drop_q),
    .mode_i  (mode_q),
    .valid_o (prep_valid),
    .ratio_o (ratio)
  );

  // Stages three and four: multiply by the reciprocal of den for quotient
  // estimates, then multiply back to get their remainders.
  pvm_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ratio_i (ratio),
    .valid_o (div_valid),
    .est_o   (est)
  );

  // Stage five: fix each estimate by at most one, apply the threshold.
  pvm_finish u_finish (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (div_valid),
    .est_i            (est),
    .thr_en_i         (thr_en_q),
    .thr_level_i      (thr_level_q),
    .valid_o          (valid_o),
    .level_fraction_o (level_fraction_o),
    .gray_level_o     (gray_level_o)
  );

`ifndef SYNTH
  // Every accepted request yields a result strobe once it has passed the pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 valid_o)
    else $error("result strobe missing five cycles after a request");

  // The metric never exceeds one.
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (level_fraction_o <= 17'd65536))
    else $error("level fraction above one");

  // In threshold mode the gray byte is a mask.
  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(thr_en_q)) |-> (gray_level_o == 8'd0 || gray_level_o == 8'd255))
    else $error("threshold mask is neither 0 nor 255");
`endif

endmodule

// ----- rtl/pvm_prep.sv -----
// Channel masking and selection of the metric ratio (two register stages).
module pvm_prep
  import pvm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  pix_t   pix_i,
  input  drop_t  drop_i,
  input  mode_e  mode_i,
  output logic   valid_o,
  output ratio_t ratio_o
);

  logic   s1_valid_q;
  pix_t   s1_pix_d, s1_pix_q;
  logic   s2_valid_q;
  ratio_t s2_ratio_d, s2_ratio_q;
  logic [7:0] hi, lo, mx, mn;

  always_comb begin
    s1_pix_d.red   = pix_i.red   & 8'(8'hFF << drop_i.red);
    s1_pix_d.green = pix_i.green & 8'(8'hFF << drop_i.green);
    s1_pix_d.blue  = pix_i.blue  & 8'(8'hFF << drop_i.blue);
    s1_pix_d.alpha = pix_i.alpha & 8'(8'hFF << drop_i.alpha);
  end

  always_comb begin
    mx = (s1_pix_q.red > s1_pix_q.green) ? s1_pix_q.red : s1_pix_q.green;
    hi = (mx > s1_pix_q.blue) ? mx : s1_pix_q.blue;
    mn = (s1_pix_q.red < s1_pix_q.green) ? s1_pix_q.red : s1_pix_q.green;
    lo = (mn < s1_pix_q.blue) ? mn : s1_pix_q.blue;
  end

  always_comb begin
    s2_ratio_d = '0;
    case (mode_i)
      MODE_AVG_RGB: begin
        s2_ratio_d.num   = 10'(s1_pix_q.red) + 10'(s1_pix_q.green) + 10'(s1_pix_q.blue);
        s2_ratio_d.den   = 10'd765;
        s2_ratio_d.recip = RECIP_765;
      end
      MODE_AVG_RGBA: begin
        s2_ratio_d.num   = 10'(s1_pix_q.red) + 10'(s1_pix_q.green) + 10'(s1_pix_q.blue)
                         + 10'(s1_pix_q.alpha);
        s2_ratio_d.den   = 10'd1020;
        s2_ratio_d.recip = RECIP_1020;
      end
      MODE_ALPHA: begin
        s2_ratio_d.num   = 10'(s1_pix_q.alpha);
        s2_ratio_d.den   = 10'd255;
        s2_ratio_d.recip = RECIP_255;
      end
      MODE_BLUE: begin
        s2_ratio_d.num   = 10'(s1_pix_q.blue);
        s2_ratio_d.den   = 10'd255;
        s2_ratio_d.recip = RECIP_255;
      end
      MODE_GREEN: begin
        s2_ratio_d.num   = 10'(s1_pix_q.green);
        s2_ratio_d.den   = 10'd255;
        s2_ratio_d.recip = RECIP_255;
      end
      MODE_RED: begin
        s2_ratio_d.num   = 10'(s1_pix_q.red);
        s2_ratio_d.den   = 10'd255;
        s2_ratio_d.recip = RECIP_255;
      end
      MODE_LIGHTNESS: begin
        s2_ratio_d.num   = 10'(hi) + 10'(lo);
        s2_ratio_d.den   = 10'd510;
        s2_ratio_d.recip = RECIP_510;
      end
      default: begin
        // Saturation; a black pixel gives 0 / 1.
        s2_ratio_d.num   = 10'(hi - lo);
        s2_ratio_d.den   = (hi == 8'd0) ? 10'd1 : 10'(hi);
        s2_ratio_d.recip = RECIP_TBL[hi];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q   <= s1_pix_d;
    s2_ratio_q <= s2_ratio_d;
  end

  assign valid_o = s2_valid_q;
  assign ratio_o = s2_ratio_q;

endmodule

// ----- rtl/pvm_divide.sv -----
// Reciprocal multiply and back-multiply giving quotient estimates and remainders.
module pvm_divide
  import pvm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  ratio_t ratio_i,
  output logic   valid_o,
  output est_t   est_o
);

  logic [17:0] num255_in;
  logic [36:0] prod_frac;
  logic [44:0] prod_gray;

  logic        s3_valid_q;
  logic [16:0] s3_frac_d, s3_frac_q;
  logic [7:0]  s3_gray_d, s3_gray_q;
  logic [9:0]  s3_num_q;
  logic [9:0]  s3_den_q;

  logic [17:0] num255;
  logic [26:0] back_frac, diff_frac;
  logic [17:0] back_gray, diff_gray;

  logic        s4_valid_q;
  est_t        s4_est_d, s4_est_q;

  // Estimates from truncated reciprocals are never high and at most one low.
  always_comb begin
    num255_in = {ratio_i.num, 8'h00} - 18'(ratio_i.num);
    prod_frac = 37'(ratio_i.num) * 37'(ratio_i.recip);
    prod_gray = 45'(num255_in) * 45'(ratio_i.recip);
    s3_frac_d = prod_frac[RecipShift:RecipShift-FracWidth+1];
    s3_gray_d = prod_gray[RecipShift+7:RecipShift];
  end

  always_comb begin
    num255    = {s3_num_q, 8'h00} - 18'(s3_num_q);
    back_frac = 27'(s3_frac_q) * 27'(s3_den_q);
    diff_frac = 27'({s3_num_q, 16'h0000}) - back_frac;
    back_gray = 18'(s3_gray_q) * 18'(s3_den_q);
    diff_gray = num255 - back_gray;
    s4_est_d.frac_est = s3_frac_q;
    s4_est_d.frac_rem = diff_frac[10:0];
    s4_est_d.gray_est = s3_gray_q;
    s4_est_d.gray_rem = diff_gray[10:0];
    s4_est_d.den      = s3_den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_frac_q <= s3_frac_d;
    s3_gray_q <= s3_gray_d;
    s3_num_q  <= ratio_i.num;
    s3_den_q  <= ratio_i.den;
    s4_est_q  <= s4_est_d;
  end

  assign valid_o = s4_valid_q;
  assign est_o   = s4_est_q;

endmodule

// ----- rtl/pvm_finish.sv -----
// Quotient correction, threshold compare and the registered result.
module pvm_finish
  import pvm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  est_t        est_i,
  input  logic        thr_en_i,
  input  logic [16:0] thr_level_i,
  output logic        valid_o,
  output logic [16:0] level_fraction_o,
  output logic [7:0]  gray_level_o
);

  logic        frac_bump, gray_bump, above;
  logic [16:0] frac_c;
  logic [10:0] rem_c;
  logic [7:0]  gray_c;

  logic        valid_q;
  logic [16:0] frac_d, frac_q;
  logic [7:0]  gray_d, gray_q;

  always_comb begin
    frac_bump = est_i.frac_rem >= 11'(est_i.den);
    frac_c    = est_i.frac_est + 17'(frac_bump);
    rem_c     = frac_bump ? est_i.frac_rem - 11'(est_i.den) : est_i.frac_rem;
    gray_bump = est_i.gray_rem >= 11'(est_i.den);
    gray_c    = est_i.gray_est + 8'(gray_bump);
    // The exact metric lies above the threshold when the floored fraction
    // does, or equals it with a nonzero remainder.
    above     = (frac_c > thr_level_i) || ((frac_c == thr_level_i) && (rem_c != 11'd0));
    frac_d    = frac_c;
    gray_d    = thr_en_i ? (above ? 8'd0 : 8'd255) : gray_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
    gray_q <= gray_d;
  end

  assign valid_o          = valid_q;
  assign level_fraction_o = frac_q;
  assign gray_level_o     = gray_q;

endmodule

// ----- tb/sv/pvm_metric_checker.sv -----
// Checker that mirrors the configuration, predicts each pixel metric and compares results.
module pvm_metric_checker
  import pvm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic [7:0]          alpha_i,
  input  logic                valid_o,
  input  logic [16:0]         level_fraction_o,
  input  logic [7:0]          gray_level_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [16:0] frac;
    logic [7:0]  gray;
  } metric_t;

  metric_t     metric_q[$];
  int          errors;

  mode_e       cur_mode;
  drop_t       cur_drop;
  logic        cur_thr_en;
  logic [16:0] cur_thr_level;

  assign fail_count_o = errors;

  // Exact rational metric num/den; both floors and the threshold test use it directly.
  function automatic metric_t predict_metric(input logic [7:0] r_in, input logic [7:0] g_in,
                                             input logic [7:0] b_in, input logic [7:0] a_in);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [63:0] num;
    logic [63:0] den;
    metric_t     res;
    r = r_in & 8'(8'hFF << cur_drop.red);
    g = g_in & 8'(8'hFF << cur_drop.green);
    b = b_in & 8'(8'hFF << cur_drop.blue);
    a = a_in & 8'(8'hFF << cur_drop.alpha);
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    case (cur_mode)
      MODE_AVG_RGB: begin
        num = 64'(r) + 64'(g) + 64'(b);
        den = 64'd765;
      end
      MODE_AVG_RGBA: begin
        num = 64'(r) + 64'(g) + 64'(b) + 64'(a);
        den = 64'd1020;
      end
      MODE_ALPHA: begin
        num = 64'(a);
        den = 64'd255;
      end
      MODE_BLUE: begin
        num = 64'(b);
        den = 64'd255;
      end
      MODE_GREEN: begin
        num = 64'(g);
        den = 64'd255;
      end
      MODE_RED: begin
        num = 64'(r);
        den = 64'd255;
      end
      MODE_LIGHTNESS: begin
        num = 64'(hi) + 64'(lo);
        den = 64'd510;
      end
      default: begin
        // A black pixel has no hue to saturate; its saturation is zero.
        if (hi == 8'd0) begin
          num = 64'd0;
          den = 64'd1;
        end else begin
          num = 64'(hi - lo);
          den = 64'(hi);
        end
      end
    endcase
    res.frac = 17'((num * 64'd65536) / den);
    if (cur_thr_en) begin
      res.gray = (num * 64'd65536 > 64'(cur_thr_level) * den) ? 8'd0 : 8'd255;
    end else begin
      res.gray = 8'((num * 64'd255) / den);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    metric_t want;
    if (!rst_ni) begin
      metric_q.delete();
      errors = 0;
      pending_o <= 0;
      cur_mode <= MODE_AVG_RGB;
      cur_drop <= '0;
      cur_thr_en <= 1'b0;
      cur_thr_level <= ThresholdReset;
    end else begin
      if (valid_o === 1'b1) begin
        if (metric_q.size() == 0) begin
          $display("%0t: result with none pending: level_fraction=%0d gray_level=%0d",
                   $time, level_fraction_o, gray_level_o);
          errors++;
        end else begin
          want = metric_q.pop_front();
          if (level_fraction_o !== want.frac) begin
            $display("%0t: level_fraction expected %0d actual %0d",
                     $time, want.frac, level_fraction_o);
            errors++;
          end
          if (gray_level_o !== want.gray) begin
            $display("%0t: gray_level expected %0d actual %0d",
                     $time, want.gray, gray_level_o);
            errors++;
          end
        end
      end else if (valid_o !== 1'b0) begin
        $display("%0t: valid_o expected 0 or 1 actual %b", $time, valid_o);
        errors++;
      end
      if (start_i && !busy_o) begin
        metric_q.push_back(predict_metric(red_i, green_i, blue_i, alpha_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DATA_MODE:        cur_mode <= mode_e'(cfg_wdata_i[2:0]);
          REG_RED_DROP_BITS:    cur_drop.red <= cfg_wdata_i[2:0];
          REG_GREEN_DROP_BITS:  cur_drop.green <= cfg_wdata_i[2:0];
          REG_BLUE_DROP_BITS:   cur_drop.blue <= cfg_wdata_i[2:0];
          REG_ALPHA_DROP_BITS:  cur_drop.alpha <= cfg_wdata_i[2:0];
          REG_THRESHOLD_ENABLE: cur_thr_en <= cfg_wdata_i[0];
          REG_THRESHOLD_LEVEL:  cur_thr_level <= cfg_wdata_i[16:0];
          default: ;
        endcase
      end
      pending_o <= metric_q.size();
    end
  end

endmodule

// ----- tb/sv/pixel_visual_metric_tb.sv -----
// Testbench top of the pixel visual metric block: clock, reset, stimulus and verdict.
module pixel_visual_metric_tb;
  import pvm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [2:0] RegUnused = 3'd7;
  // Spare cycles waited once the last pending result has come back.
  localparam int SettleCycles = 8;
  localparam int Segments     = 20;
  localparam int SegmentItems = 30;
  // Generous bound on the length of the whole run.
  localparam int CycleLimit   = 200000;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [7:0]          red_i;
  logic [7:0]          green_i;
  logic [7:0]          blue_i;
  logic [7:0]          alpha_i;
  logic                valid_o;
  logic [16:0]         level_fraction_o;
  logic [7:0]          gray_level_o;
  logic                cfg_we_i;
  logic [2:0]          cfg_idx_i;
  logic [CfgWidth-1:0] cfg_wdata_i;
  int                  fail_count;
  int                  pending;

  pixel_visual_metric uut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .red_i,
    .green_i,
    .blue_i,
    .alpha_i,
    .valid_o,
    .level_fraction_o,
    .gray_level_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  pvm_metric_checker checker_i (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .red_i,
    .green_i,
    .blue_i,
    .alpha_i,
    .valid_o,
    .level_fraction_o,
    .gray_level_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung block or a lost result ends the run here.
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // Presents one request at the falling edge and holds it until the block takes it.
  // start_i stays high between back-to-back requests, so it is never lowered and
  // raised again within one time step.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    @(negedge clk_i);
    start_i <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    alpha_i <= a;
    do @(posedge clk_i); while (busy_o);
  endtask

  // The sender goes quiet for the number of cycles given; the data ports carry junk meanwhile,
  // which the block must ignore.
  task automatic pause_sender(input int cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    red_i   <= 8'($urandom);
    green_i <= 8'($urandom);
    blue_i  <= 8'($urandom);
    alpha_i <= 8'($urandom);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Registers may only change while the pipeline is empty: stop sending, wait for
  // every pending result, then give the pipeline a few spare cycles.
  task automatic drain_pipeline();
    pause_sender(1);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Bits above the register width are filled with noise; the block must drop them.
  task automatic write_reg(input logic [2:0] idx, input int unsigned value,
                           input int unsigned width);
    logic [CfgWidth-1:0] noise;
    noise = (width >= CfgWidth) ? '0 : CfgWidth'($urandom << width);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgWidth'(value) | noise;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic write_drops(input int unsigned r, input int unsigned g,
                             input int unsigned b, input int unsigned a);
    write_reg(REG_RED_DROP_BITS, r, 3);
    write_reg(REG_GREEN_DROP_BITS, g, 3);
    write_reg(REG_BLUE_DROP_BITS, b, 3);
    write_reg(REG_ALPHA_DROP_BITS, a, 3);
  endtask

  function automatic int unsigned pick_drop();
    return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 7);
  endfunction

  initial begin : stimulus
    int unsigned sender_idle_pct;
    int unsigned kind;
    int unsigned thr_pick;
    int unsigned thr_level;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    alpha_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: every metric on black, full white and a mixed pixel. The
    // threshold is swept over zero, exactly one and its top value, and the drop
    // registers over both extremes. Black in saturation mode checks the zero
    // maximum case; black against a zero threshold and white against a threshold
    // of exactly one check that a tie does not count as above.
    for (int m = 0; m < 8; m++) begin
      drain_pipeline();
      write_reg(REG_DATA_MODE, m, 3);
      case (mode_e'(m))
        MODE_ALPHA: begin
          write_reg(REG_THRESHOLD_ENABLE, 1, 1);
          write_reg(REG_THRESHOLD_LEVEL, 0, 17);
        end
        MODE_BLUE: begin
          write_reg(REG_THRESHOLD_LEVEL, 65536, 17);
          // A write to an unused index must leave every register alone.
          write_reg(RegUnused, $urandom, 17);
        end
        MODE_GREEN: begin
          write_reg(REG_THRESHOLD_LEVEL, 131071, 17);
          write_drops(7, 7, 7, 7);
        end
        MODE_RED: write_reg(REG_THRESHOLD_ENABLE, 0, 1);
        MODE_LIGHTNESS: write_drops(0, 0, 0, 0);
        default: ;
      endcase
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hA5, 8'h5A, 8'h3C, 8'hC3);
    end

    // Random part: each segment loads a fresh configuration and then streams
    // pixels. The first third of the segments has a mostly busy sender, the
    // second a mostly quiet one, the last sends back to back.
    for (int seg = 0; seg < Segments; seg++) begin
      if (seg < Segments / 3) begin
        sender_idle_pct = 9;
      end else if (seg < 2 * Segments / 3) begin
        sender_idle_pct = 84;
      end else begin
        sender_idle_pct = 0;
      end
      drain_pipeline();
      write_reg(REG_DATA_MODE, (seg % 8 == 0) ? $urandom_range(0, 7) : seg % 8, 3);
      write_drops(pick_drop(), pick_drop(), pick_drop(), pick_drop());
      write_reg(REG_THRESHOLD_ENABLE, $urandom_range(0, 1), 1);
      thr_pick = $urandom_range(0, 5);
      case (thr_pick)
        0: thr_level = 0;
        1: thr_level = 65536;
        2: thr_level = $urandom_range(65537, 131071);
        default: thr_level = $urandom_range(0, 65536);
      endcase
      write_reg(REG_THRESHOLD_LEVEL, thr_level, 17);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(RegUnused, $urandom, 17);
      end

      for (int n = 0; n < SegmentItems; n++) begin
        // Each cycle is idle with the segment's chance, so gaps run geometric.
        while ($urandom_range(0, 99) < sender_idle_pct) begin
          pause_sender(1);
        end
        kind = $urandom_range(0, 9);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        a = 8'($urandom);
        case (kind)
          0: begin
            // Black RGB, random alpha.
            r = 8'h00;
            g = 8'h00;
            b = 8'h00;
          end
          1: begin
            // Each channel at one of its extremes.
            r = {8{r[0]}};
            g = {8{g[0]}};
            b = {8{b[0]}};
            a = {8{a[0]}};
          end
          2: begin
            // Gray pixel: saturation zero, lightness equal to the channel.
            g = r;
            b = r;
          end
          default: ;
        endcase
        send_pixel(r, g, b, a);
      end
    end

    // Drain, then wait out the pipeline latency once more for stray results.
    pause_sender(1);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- pixel_visual_metric.f -----
rtl/pvm_pkg.sv
rtl/pvm_prep.sv
rtl/pvm_divide.sv
rtl/pvm_finish.sv
rtl/pixel_visual_metric.sv
tb/sv/pvm_metric_checker.sv
tb/sv/pixel_visual_metric_tb.sv
